@@ hw/rtl/rpid_pkg.sv @@
// ----------------------------------------------------------------------------
// rpid_pkg
// Shared types and constants for the run-length palette picture decoder.
// ----------------------------------------------------------------------------
package rpid_pkg;

    localparam int PALETTE_DEPTH_DEF = 128;
    localparam int QUEUE_DEPTH       = 4;

    localparam int IDX_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int COLOUR_W = 16;
    localparam int LEN_W    = 9;

    localparam logic [BYTE_W-1:0] END_MARK    = 8'hFF;
    localparam logic [IDX_W-1:0]  ALPHA_INDEX = 7'h0F;
    localparam int                RUN_FLAG_BIT = 7;

    localparam logic [LEN_W-1:0] SINGLE_LEN = 9'd1;
    localparam logic [LEN_W-1:0] RUN_BIAS   = 9'd2;

    // Operations handed from parser to executor
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_END   = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [IDX_W-1:0]      index;   // palette slot or lookup index
        logic                  zero;    // lookup lies beyond the palette
        logic [LEN_W-1:0]      len;
        logic [COLOUR_W-1:0]   value;   // colour for a palette write
    } op_t;

endpackage

@@ hw/rtl/rle_palette_image_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_palette_image_decoder
// Run-length palette picture decoder: bytes and palette writes in, one run
// descriptor (colour, length, end flag) out per run or end marker.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  in      | in_valid / in_stall       | action, picture_byte, palette_slot,
//          |                           | palette_value
//  out     | out_valid / out_stall     | pixel_colour, run_length, picture_done
//  cfg     | cfg_write                 | cfg_data (substitute for index 15)
//
// One word a cycle sustained while in_stall is low; palette writes and lookups
// reach the palette RAM in order, taken from a four-entry queue.
// An input word passes the queue, the RAM read stage and the output register.
// Reset clears parser phase, queue and valids; palette contents stay undefined
// until written, and there is no clearing pass.
// in_stall rises only when the queue is full, i.e. after sustained out_stall.
// ----------------------------------------------------------------------------
module rle_palette_image_decoder
    import rpid_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [IDX_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [BYTE_W-1:0]   picture_byte,
    input  logic [IDX_W-1:0]    palette_slot,
    input  logic [COLOUR_W-1:0] palette_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [COLOUR_W-1:0] pixel_colour,
    output logic [LEN_W-1:0]    run_length,
    output logic                picture_done
);

    logic accept;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    op_t  push_op;
    op_t  q_head;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    rpid_front #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .action       (action),
        .picture_byte (picture_byte),
        .palette_slot (palette_slot),
        .palette_value(palette_value),
        .push         (q_push),
        .op           (push_op)
    );

    rpid_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .push_op(push_op),
        .pop    (q_pop),
        .head   (q_head),
        .empty  (q_empty),
        .full   (q_full)
    );

    rpid_back #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .empty       (q_empty),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_colour(pixel_colour),
        .run_length  (run_length),
        .picture_done(picture_done)
    );

`ifndef ASSERT_OFF
    // end marker word carries no colour and no length
    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && picture_done |-> run_length == '0 && pixel_colour == '0)
        else $error("end word with non-zero payload");

    // every run word covers at least one pixel
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !picture_done |-> run_length != '0)
        else $error("run word with zero length");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full || q_pop)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");
`endif

endmodule

@@ hw/rtl/rpid_ram.sv @@
// ----------------------------------------------------------------------------
// rpid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/rpid_front.sv @@
// ----------------------------------------------------------------------------
// rpid_front
// Byte parser: tracks header/index/count phase, applies the transparent
// index substitution and queues elements and in-range palette writes.
// ----------------------------------------------------------------------------
module rpid_front
    import rpid_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [IDX_W-1:0]    cfg_data,
    input  logic                accept,
    input  logic                action,
    input  logic [BYTE_W-1:0]   picture_byte,
    input  logic [IDX_W-1:0]    palette_slot,
    input  logic [COLOUR_W-1:0] palette_value,
    output logic                push,
    output op_t                 op
);

    typedef enum logic [1:0] {
        PH_HEAD0 = 2'd0,
        PH_HEAD1 = 2'd1,
        PH_INDEX = 2'd2,
        PH_COUNT = 2'd3
    } phase_t;

    localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W+1)'(PALETTE_DEPTH);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] pending_reg, pending_next;
    logic [IDX_W-1:0] alpha_reg;
    logic [IDX_W-1:0] look_idx;
    logic [IDX_W-1:0] sub_idx;

    // index to look up: the held one in count phase, else the byte itself
    assign look_idx = (phase_reg == PH_COUNT) ? pending_reg : picture_byte[IDX_W-1:0];
    assign sub_idx  = (look_idx == ALPHA_INDEX) ? alpha_reg : look_idx;

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        push         = 1'b0;
        op.kind      = OP_RUN;
        op.index     = sub_idx;
        op.zero      = ({1'b0, sub_idx} >= DEPTH_LIM);
        op.len       = SINGLE_LEN;
        op.value     = palette_value;

        if (accept)
        begin
            if (!action)
            begin
                op.kind  = OP_WRITE;
                op.index = palette_slot;
                push     = ({1'b0, palette_slot} < DEPTH_LIM);
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEAD0: phase_next = PH_HEAD1;
                    PH_HEAD1: phase_next = PH_INDEX;
                    PH_INDEX:
                    begin
                        priority if (picture_byte == END_MARK)
                        begin
                            op.kind    = OP_END;
                            op.zero    = 1'b1;
                            op.len     = '0;
                            push       = 1'b1;
                            phase_next = PH_HEAD0;
                        end
                        else if (picture_byte[RUN_FLAG_BIT])
                        begin
                            pending_next = picture_byte[IDX_W-1:0];
                            phase_next   = PH_COUNT;
                        end
                        else
                        begin
                            push = 1'b1;
                        end
                    end
                    PH_COUNT:
                    begin
                        op.len     = {1'b0, picture_byte} + RUN_BIAS;
                        push       = 1'b1;
                        phase_next = PH_INDEX;
                    end
                    default: phase_next = PH_HEAD0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEAD0;
            pending_reg <= '0;
            alpha_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            if (cfg_write)
            begin
                alpha_reg <= cfg_data;
            end
        end
    end

endmodule

@@ hw/rtl/rpid_queue.sv @@
// ----------------------------------------------------------------------------
// rpid_queue
// Small in-order operation queue between parser and executor.
// ----------------------------------------------------------------------------
module rpid_queue
    import rpid_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head,
    output logic empty,
    output logic full
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    op_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

@@ hw/rtl/rpid_back.sv @@
// ----------------------------------------------------------------------------
// rpid_back
// Executor: applies palette writes, looks up run colours and holds the
// result word in an output register.
// ----------------------------------------------------------------------------
module rpid_back
    import rpid_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  op_t                 head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [COLOUR_W-1:0] pixel_colour,
    output logic [LEN_W-1:0]    run_length,
    output logic                picture_done
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_zero_reg;
    logic [LEN_W-1:0]    s1_len_reg;
    logic                s1_done_reg;
    logic                out_valid_reg, out_valid_next;
    logic [COLOUR_W-1:0] colour_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                done_reg;
    logic                out_free;
    logic                s1_ready;
    logic                is_write;
    logic                ram_we;
    logic                ram_re;
    logic [COLOUR_W-1:0] ram_rdata;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || out_free;
    assign is_write = (head.kind == OP_WRITE);
    // writes never touch the lookup stage, so they drain even while it waits
    assign pop      = !empty && (is_write || s1_ready);
    assign ram_we   = pop && is_write;
    assign ram_re   = pop && (head.kind == OP_RUN) && !head.zero;

    rpid_ram #(
        .WIDTH(COLOUR_W),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .clk  (clk),
        .we   (ram_we),
        .waddr(head.index[AW-1:0]),
        .wdata(head.value),
        .re   (ram_re),
        .raddr(head.index[AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = pop && !is_write;
        end
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pop && !is_write)
        begin
            s1_zero_reg <= head.zero;
            s1_len_reg  <= head.len;
            s1_done_reg <= (head.kind == OP_END);
        end
        if (out_free && s1_valid_reg)
        begin
            colour_reg <= s1_zero_reg ? '0 : ram_rdata;
            len_reg    <= s1_len_reg;
            done_reg   <= s1_done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_colour = colour_reg;
    assign run_length   = len_reg;
    assign picture_done = done_reg;

endmodule

@@ sim/rle_palette_image_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// rle_palette_image_decoder_tb
// Self-checking bench for the run-length palette picture decoder. Loads the
// whole palette, then drives directed and random compressed pictures, noise
// and palette rewrites under random input gaps and output stalls. Each run
// descriptor is checked against an in-bench decoder of the byte stream.
// ----------------------------------------------------------------------------
module rle_palette_image_decoder_tb
    import rpid_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 10;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic        ACT_PALETTE   = 1'b0;
    localparam logic        ACT_BYTE      = 1'b1;
    localparam logic [IDX_W-1:0] TOP_INDEX = 7'h7F;

    typedef enum logic [1:0] {
        PH_HEAD0,
        PH_HEAD1,
        PH_INDEX,
        PH_COUNT
    } stream_phase_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic [LEN_W-1:0]    len;
        logic                done;
    } run_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [IDX_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                action;
    logic [BYTE_W-1:0]   picture_byte;
    logic [IDX_W-1:0]    palette_slot;
    logic [COLOUR_W-1:0] palette_value;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [COLOUR_W-1:0] pixel_colour;
    logic [LEN_W-1:0]    run_length;
    logic                picture_done;

    // decoder state mirrored in the bench
    logic [COLOUR_W-1:0] colour_table [PALETTE_DEPTH_DEF];
    stream_phase_t       phase_q;
    logic [IDX_W-1:0]    run_index_q;
    logic [IDX_W-1:0]    subst_index;
    run_t                expected_runs [$];

    bit          sender_idles    = 1'b0;
    bit          receiver_stalls = 1'b0;
    int unsigned stall_left      = 0;
    int unsigned cycle_count     = 0;
    int unsigned words_sent      = 0;
    int unsigned runs_checked    = 0;
    int unsigned ends_checked    = 0;
    int unsigned mismatch_count  = 0;
    run_t        want;

    rle_palette_image_decoder #(
        .PALETTE_DEPTH (PALETTE_DEPTH_DEF)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .picture_byte  (picture_byte),
        .palette_slot  (palette_slot),
        .palette_value (palette_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_colour  (pixel_colour),
        .run_length    (run_length),
        .picture_done  (picture_done)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("rle_palette_image_decoder_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // random lengths: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned stall_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (receiver_stalls && $urandom_range(0, 99) < 25)
        begin
            stall_left <= stall_len() - 1;
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // stream decoder
    // ------------------------------------------------------------------
    function automatic logic [COLOUR_W-1:0] palette_colour(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] i;
        i = (idx == ALPHA_INDEX) ? subst_index : idx;
        return colour_table[i];
    endfunction

    function automatic void decode_word(input logic                act,
                                        input logic [BYTE_W-1:0]   b,
                                        input logic [IDX_W-1:0]    slot,
                                        input logic [COLOUR_W-1:0] value);
        run_t r;
        bit   has_run;
        has_run = 1'b0;
        r       = '0;
        if (act == ACT_PALETTE)
        begin
            colour_table[slot] = value;
        end
        else
        begin
            case (phase_q)
                PH_HEAD0: phase_q = PH_HEAD1;
                PH_HEAD1: phase_q = PH_INDEX;
                PH_INDEX:
                begin
                    if (b == END_MARK)
                    begin
                        phase_q = PH_HEAD0;
                        r.done  = 1'b1;
                        has_run = 1'b1;
                    end
                    else if (b[RUN_FLAG_BIT])
                    begin
                        run_index_q = b[IDX_W-1:0];
                        phase_q     = PH_COUNT;
                    end
                    else
                    begin
                        r.colour = palette_colour(b[IDX_W-1:0]);
                        r.len    = SINGLE_LEN;
                        has_run  = 1'b1;
                    end
                end
                default:
                begin
                    // count byte: any value, 0xFF included, is a plain count
                    phase_q  = PH_INDEX;
                    r.colour = palette_colour(run_index_q);
                    r.len    = {1'b0, b} + RUN_BIAS;
                    has_run  = 1'b1;
                end
            endcase
        end
        if (has_run)
            expected_runs.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_runs.size() == 0)
            begin
                flag_mismatch("unexpected word, colour", 32'd0, 32'(pixel_colour));
            end
            else
            begin
                want = expected_runs.pop_front();
                if (pixel_colour !== want.colour)
                    flag_mismatch("pixel_colour", 32'(want.colour), 32'(pixel_colour));
                if (run_length !== want.len)
                    flag_mismatch("run_length", 32'(want.len), 32'(run_length));
                if (picture_done !== want.done)
                    flag_mismatch("picture_done", 32'(want.done), 32'(picture_done));
                runs_checked++;
                if (want.done)
                    ends_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_word(input logic                act,
                             input logic [BYTE_W-1:0]   b,
                             input logic [IDX_W-1:0]    slot,
                             input logic [COLOUR_W-1:0] value);
        int unsigned gap;
        gap = sender_idles ? idle_len() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        picture_byte  <= b;
        palette_slot  <= slot;
        palette_value <= value;
        do
            @(posedge clk);
        while (in_stall);
        decode_word(act, b, slot, value);
        words_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_word(ACT_BYTE, b, IDX_W'($urandom), COLOUR_W'($urandom));
    endtask

    task automatic write_colour(input logic [IDX_W-1:0] slot, input logic [COLOUR_W-1:0] value);
        send_word(ACT_PALETTE, BYTE_W'($urandom), slot, value);
    endtask

    // sender holds off until every run is out and the pipe has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_substitute(input logic [IDX_W-1:0] v);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write   <= 1'b0;
        subst_index = v;
    endtask

    function automatic logic [IDX_W-1:0] pick_index(input int unsigned top);
        if ($urandom_range(0, 9) == 0)
            return ALPHA_INDEX;
        return IDX_W'($urandom_range(0, top));
    endfunction

    // well-formed picture, or one cut short before its end marker
    task automatic send_picture(input int unsigned n_elems, input bit closed);
        int unsigned pick;
        send_byte(BYTE_W'($urandom));
        send_byte(BYTE_W'($urandom));
        repeat (n_elems)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_byte({1'b0, pick_index(TOP_INDEX)});
            end
            else if (pick < 85)
            begin
                // index 127 cannot start a run: 0xFF is the end marker
                send_byte({1'b1, pick_index(TOP_INDEX - 1)});
                pick = $urandom_range(0, 9);
                send_byte(pick == 0 ? 8'hFF : pick == 1 ? 8'h00 : BYTE_W'($urandom));
            end
            else
            begin
                write_colour(IDX_W'($urandom), COLOUR_W'($urandom));
            end
        end
        if (closed)
            send_byte(END_MARK);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_palette_load();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        write_colour(7'd0, 16'h0000);
        for (int s = 1; s < PALETTE_DEPTH_DEF - 1; s++)
            write_colour(IDX_W'(s), COLOUR_W'($urandom));
        write_colour(TOP_INDEX, 16'hFFFF);
    endtask

    task automatic test_directed_picture();
        set_substitute(TOP_INDEX);
        send_byte(END_MARK);        // header bytes are skipped, even 0xFF
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte({1'b0, ALPHA_INDEX});
        send_byte(8'h80);           // shortest run
        send_byte(8'h00);
        send_byte(8'hFE);           // longest run
        send_byte(8'hFF);
        send_byte({1'b1, ALPHA_INDEX});
        send_byte(8'h01);
        write_colour(TOP_INDEX, 16'h5AA5);
        send_byte(8'h7F);
        send_byte(8'h81);           // palette rewrite between run start and count
        write_colour(7'd1, 16'hFFFF);
        send_byte(8'h80);
        send_byte(END_MARK);
        send_byte(8'h80);           // empty picture
        send_byte(8'h7F);
        send_byte(END_MARK);
        wait_drained();
    endtask

    task automatic test_substitute_settings();
        logic [IDX_W-1:0] settings [4];
        settings = '{7'd0, ALPHA_INDEX, IDX_W'($urandom), TOP_INDEX};
        foreach (settings[k])
        begin
            set_substitute(settings[k]);
            send_byte(BYTE_W'($urandom));
            send_byte(BYTE_W'($urandom));
            send_byte({1'b0, ALPHA_INDEX});
            send_byte({1'b1, ALPHA_INDEX});
            send_byte(BYTE_W'($urandom));
            send_byte(END_MARK);
        end
        wait_drained();
    endtask

    task automatic test_random_pictures(input int unsigned target, input bit idles,
                                        input bit stalls);
        int unsigned first;
        int unsigned pics;
        int unsigned r;
        sender_idles    = idles;
        receiver_stalls = stalls;
        first           = words_sent;
        pics            = 0;
        while (words_sent - first < target)
        begin
            r = $urandom_range(0, 9);
            if (r < 8)
            begin
                send_picture($urandom_range(2, 16), 1'b1);
            end
            else if (r == 8)
            begin
                send_picture($urandom_range(1, 6), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(3, 12))
                    send_word(logic'($urandom_range(0, 1)), BYTE_W'($urandom),
                              IDX_W'($urandom), COLOUR_W'($urandom));
            end
            pics++;
            if (pics % 6 == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        action        <= ACT_BYTE;
        picture_byte  <= '0;
        palette_slot  <= '0;
        palette_value <= '0;
        phase_q       = PH_HEAD0;
        run_index_q   = '0;
        subst_index   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_palette_load();
        test_directed_picture();
        test_substitute_settings();
        set_substitute(IDX_W'($urandom));
        test_random_pictures(400, 1'b1, 1'b1);
        set_substitute(7'd0);
        test_random_pictures(250, 1'b0, 1'b0);
        set_substitute(ALPHA_INDEX);
        test_random_pictures(250, 1'b0, 1'b1);
        set_substitute(TOP_INDEX);
        test_random_pictures(250, 1'b1, 1'b0);

        $display("summary: %0d words in, %0d runs checked, %0d of them picture ends",
                 words_sent, runs_checked, ends_checked);
        $display("summary: substitute index swept over 0, 15, 127 and random; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("rle_palette_image_decoder_tb: clean");
        else
            $display("rle_palette_image_decoder_tb: errors");
        $finish;
    end

endmodule
